>>> rtl/rxs_pkg.sv
`default_nettype none

package rxs_pkg;

  // Default geometry of the record store
  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_BITS_DEF    = 20;

  // Fixed field widths of the record ports
  localparam int CODE_W  = 20;
  localparam int STOCK_W = 32;
  localparam int TAG_W   = 16;

endpackage

`default_nettype wire

>>> rtl/record_exchange_sort.sv
`default_nettype none

// Batch record sorter. Records (code, stock, desc_handle) are collected one per
// cycle until the transfer with last set. Up to MAX_RECORDS records are kept.
// Later records are dropped, and overflow is then flagged on every result of
// that batch. The batch is ordered ascending by the low KEY_BITS of code with
// an in-place exchange sort. Records with equal keys come out in the order that
// this exchange sort leaves them. The sorted records are then streamed out, one
// per cycle while out_ready is high, with last_res on the final one. in_ready
// stays low from the last record of a batch until its final result has been
// taken. The sort phase is bounded by the single read port of the record
// memory, which feeds one key comparator.
module record_exchange_sort #(
  parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF,
  parameter int KEY_BITS    = rxs_pkg::KEY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic        [rxs_pkg::CODE_W-1:0]  code,
  input  logic signed [rxs_pkg::STOCK_W-1:0] stock,
  input  logic        [rxs_pkg::TAG_W-1:0]   desc_handle,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [rxs_pkg::CODE_W-1:0]  code_res,
  output logic signed [rxs_pkg::STOCK_W-1:0] stock_res,
  output logic        [rxs_pkg::TAG_W-1:0]   desc_handle_res,
  output logic                              last_res,
  output logic                              overflow
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int REC_W = KEY_BITS + rxs_pkg::STOCK_W + rxs_pkg::TAG_W;
  localparam int KEY_LO = rxs_pkg::STOCK_W + rxs_pkg::TAG_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_LDCUR = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] k;
  logic [REC_W-1:0] cur;

  // Record memory: one write port, one registered read port
  logic [REC_W-1:0] mem [MAX_RECORDS];
  logic [REC_W-1:0] rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [REC_W-1:0] wr_data;

  logic             in_xfer;
  logic             out_xfer;
  logic             full;
  logic [CNT_W-1:0] i_inc;
  logic [CNT_W-1:0] j_inc;
  logic [CNT_W-1:0] k_inc;
  logic             sort_done;
  logic             j_last;
  logic             k_last;
  logic             swap;
  logic [REC_W-1:0] in_rec;

  assign in_ready  = (state == S_LOAD);
  assign out_valid = (state == S_EMIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign full      = (count == CNT_W'(MAX_RECORDS));
  assign i_inc     = i + CNT_W'(1);
  assign j_inc     = j + CNT_W'(1);
  assign k_inc     = k + CNT_W'(1);
  assign sort_done = (i_inc >= count);
  assign j_last    = (j_inc == count);
  assign k_last    = (k_inc == count);

  // The held record at position i is larger than the one read at j
  assign swap   = (cur[REC_W-1:KEY_LO] > rd_data[REC_W-1:KEY_LO]);
  assign in_rec = {KEY_BITS'(code), stock, desc_handle};

  // Memory port selection per sequencer step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = in_rec;
    case (state)
      S_LOAD: begin
        wr_en = in_xfer && !full;
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = sort_done ? '0 : i[IDX_W-1:0];
      end
      S_LDCUR: begin
        rd_en   = 1'b1;
        rd_addr = i_inc[IDX_W-1:0];
      end
      S_CMP: begin
        rd_en   = 1'b1;
        rd_addr = j_inc[IDX_W-1:0];
        wr_en   = swap;
        wr_addr = j[IDX_W-1:0];
        wr_data = cur;
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = i[IDX_W-1:0];
        wr_data = cur;
      end
      S_EMIT: begin
        rd_en   = out_xfer && !k_last;
        rd_addr = k_inc[IDX_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Held record for position i; takes the smaller record on each swap
  always_ff @(posedge clk) begin
    if (state == S_LDCUR) begin
      cur <= rd_data;
    end else if (state == S_CMP && swap) begin
      cur <= rd_data;
    end
  end

  // Sequencer: load, then for each i scan j = i+1 .. n-1, then stream out
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (!full) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              i     <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (sort_done) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_LDCUR;
          end
        end
        S_LDCUR: begin
          j     <= i_inc;
          state <= S_CMP;
        end
        S_CMP: begin
          if (j_last) begin
            state <= S_WB;
          end else begin
            j <= j_inc;
          end
        end
        S_WB: begin
          i     <= i_inc;
          state <= S_FETCH;
        end
        S_EMIT: begin
          if (out_xfer) begin
            if (k_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k <= k_inc;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Results come straight from the registered memory read
  assign code_res        = rxs_pkg::CODE_W'(rd_data[REC_W-1:KEY_LO]);
  assign stock_res       = rd_data[KEY_LO-1:rxs_pkg::TAG_W];
  assign desc_handle_res = rd_data[rxs_pkg::TAG_W-1:0];
  assign last_res        = k_last;
  assign overflow        = ovf;

endmodule

`default_nettype wire

>>> test/tb_record_exchange_sort.sv
`timescale 1ns / 100ps

module tb_record_exchange_sort;

  localparam int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF;
  localparam int KEY_BITS    = rxs_pkg::KEY_BITS_DEF;
  localparam logic [rxs_pkg::CODE_W-1:0] KEY_MASK =
    {rxs_pkg::CODE_W{1'b1}} >> (rxs_pkg::CODE_W - KEY_BITS);
  localparam logic [rxs_pkg::CODE_W-1:0] CODE_MAX = {rxs_pkg::CODE_W{1'b1}};
  localparam int MAX_WAIT = 10;
  localparam int TARGET_RECORDS = 250;

  typedef struct {
    logic        [rxs_pkg::CODE_W-1:0]  code;
    logic signed [rxs_pkg::STOCK_W-1:0] stock;
    logic        [rxs_pkg::TAG_W-1:0]   tag;
  } record_t;

  typedef struct {
    logic        [rxs_pkg::CODE_W-1:0]  code;
    logic signed [rxs_pkg::STOCK_W-1:0] stock;
    logic        [rxs_pkg::TAG_W-1:0]   tag;
    logic                               last;
    logic                               overflow;
  } sorted_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               in_valid    = 1'b0;
  logic                               in_ready;
  logic        [rxs_pkg::CODE_W-1:0]  code        = '0;
  logic signed [rxs_pkg::STOCK_W-1:0] stock       = '0;
  logic        [rxs_pkg::TAG_W-1:0]   desc_handle = '0;
  logic                               last        = 1'b0;
  logic                               out_valid;
  logic                               out_ready   = 1'b0;
  logic        [rxs_pkg::CODE_W-1:0]  code_res;
  logic signed [rxs_pkg::STOCK_W-1:0] stock_res;
  logic        [rxs_pkg::TAG_W-1:0]   desc_handle_res;
  logic                               last_res;
  logic                               overflow;

  // Predictor state: records held for the open batch
  record_t     held [MAX_RECORDS];
  int          held_count    = 0;
  bit          batch_dropped = 1'b0;
  sorted_rec_t sorted_results [$];

  int fails        = 0;
  int records_sent = 0;
  bit src_steady   = 1'b0;
  bit sink_steady  = 1'b0;

  record_exchange_sort uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .code            (code),
    .stock           (stock),
    .desc_handle     (desc_handle),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .code_res        (code_res),
    .stock_res       (stock_res),
    .desc_handle_res (desc_handle_res),
    .last_res        (last_res),
    .overflow        (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Exchange sort of the held batch: swap whole records when key i > key j
  function automatic void sort_held_batch();
    record_t tmp;
    for (int i = 0; i + 1 < held_count; i++) begin
      for (int j = i + 1; j < held_count; j++) begin
        if (held[i].code > held[j].code) begin
          tmp     = held[i];
          held[i] = held[j];
          held[j] = tmp;
        end
      end
    end
  endfunction

  // Store one accepted record; on last, sort and queue the whole batch
  function automatic void absorb_record(record_t r, bit is_last);
    sorted_rec_t res;
    r.code = r.code & KEY_MASK;
    if (held_count < MAX_RECORDS) begin
      held[held_count] = r;
      held_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (is_last) begin
      sort_held_batch();
      for (int k = 0; k < held_count; k++) begin
        res.code     = held[k].code;
        res.stock    = held[k].stock;
        res.tag      = held[k].tag;
        res.last     = (k == held_count - 1);
        res.overflow = batch_dropped;
        sorted_results.push_back(res);
      end
      held_count    = 0;
      batch_dropped = 1'b0;
    end
  endfunction

  // One record transfer, with a random gap ahead of it
  task automatic send_record(input logic [rxs_pkg::CODE_W-1:0] c,
                             input logic signed [rxs_pkg::STOCK_W-1:0] s,
                             input logic [rxs_pkg::TAG_W-1:0] t, input bit is_last);
    int gap;
    record_t r;
    gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    code        <= c;
    stock       <= s;
    desc_handle <= t;
    last        <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r.code  = c;
    r.stock = s;
    r.tag   = t;
    absorb_record(r, is_last);
    records_sent++;
  endtask

  // Key draw: narrow range forces ties, wide range hits the extremes
  function automatic logic [rxs_pkg::CODE_W-1:0] pick_code(bit narrow);
    int sel;
    sel = $urandom_range(0, 9);
    if (narrow)
      return rxs_pkg::CODE_W'($urandom_range(0, 7));
    if (sel == 0)
      return '0;
    if (sel == 1)
      return CODE_MAX;
    return rxs_pkg::CODE_W'($urandom);
  endfunction

  task automatic send_batch(input int n, input bit narrow);
    for (int k = 0; k < n; k++) begin
      send_record(pick_code(narrow), $urandom, rxs_pkg::TAG_W'($urandom_range(0, 65535)),
                  k == n - 1);
    end
  endtask

  task automatic test_single_records();
    send_record(CODE_MAX, 32'sh8000_0000, 16'hFFFF, 1'b1);
    send_record('0, 32'sh7FFF_FFFF, 16'h0000, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_record(CODE_MAX, -32'sd1, 16'h0001, 1'b0);
    send_record('0, 32'sd0, 16'hFFFF, 1'b0);
    send_record(20'h80000, 32'sh8000_0000, 16'h8000, 1'b0);
    send_record(20'h00001, 32'sh7FFF_FFFF, 16'h7FFF, 1'b0);
    send_record(20'h7FFFF, 32'sh5555_5555, 16'hAAAA, 1'b0);
    send_record(20'hFFFFE, 32'shAAAA_AAAA, 16'h5555, 1'b1);
  endtask

  // Equal keys with distinct tags expose the tie order of the exchange sort
  task automatic test_equal_keys();
    logic [rxs_pkg::CODE_W-1:0] keys [8] =
      '{20'd3, 20'd3, 20'd1, 20'd3, 20'd1, 20'd2, 20'd3, 20'd1};
    for (int k = 0; k < 8; k++) begin
      send_record(keys[k], k * 1000 - 3500, rxs_pkg::TAG_W'(16'h0100 + k), k == 7);
    end
  endtask

  task automatic test_reverse_order();
    for (int k = 0; k < 5; k++) begin
      send_record(rxs_pkg::CODE_W'(50 - k * 10), -k, rxs_pkg::TAG_W'(16'h0200 + k),
                  k == 4);
    end
  endtask

  task automatic test_full_batch();
    src_steady = 1'b0;
    send_batch(MAX_RECORDS, 1'b0);
  endtask

  // Capacity plus one: the last record itself is dropped
  task automatic test_overflow_batch();
    src_steady = 1'b1;
    send_batch(MAX_RECORDS + 1, 1'b1);
  endtask

  task automatic test_random_batches();
    while (records_sent < TARGET_RECORDS) begin
      src_steady = ($urandom_range(0, 3) == 0);
      send_batch($urandom_range(1, 12), 1'($urandom_range(0, 1)));
    end
  endtask

  // Result side: random stall per result, with occasional steady stretches
  always begin
    int stall;
    if ($urandom_range(0, 19) == 0)
      sink_steady = !sink_steady;
    stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ready <= 1'b1;
    @(posedge clk);
    while (!(out_valid && !rst)) @(posedge clk);
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    sorted_rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (sorted_results.size() == 0) begin
        $error("unexpected result: code_res %0h", code_res);
        fails++;
      end else begin
        want = sorted_results.pop_front();
        if (code_res !== want.code) begin
          $error("code_res: expected %0h, got %0h", want.code, code_res);
          fails++;
        end
        if (stock_res !== want.stock) begin
          $error("stock_res: expected %0d, got %0d", want.stock, stock_res);
          fails++;
        end
        if (desc_handle_res !== want.tag) begin
          $error("desc_handle_res: expected %0h, got %0h", want.tag, desc_handle_res);
          fails++;
        end
        if (last_res !== want.last) begin
          $error("last_res: expected %0b, got %0b", want.last, last_res);
          fails++;
        end
        if (overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, overflow);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_records();
    test_field_extremes();
    test_equal_keys();
    test_reverse_order();
    test_full_batch();
    test_overflow_batch();
    test_random_batches();
    in_valid <= 1'b0;
    while (sorted_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
